// File: rtl/core/breakpoint_map_bilinear_lookup_macros.svh
// Assertion macros used by the checker of the breakpoint map lookup.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef BREAKPOINT_MAP_BILINEAR_LOOKUP_MACROS_SVH
`define BREAKPOINT_MAP_BILINEAR_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMBL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("concurrent assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BMBL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("concurrent assertion failed");

`endif

// File: rtl/core/bmbl_pkg.sv
package bmbl_pkg;

	// Table geometry
	localparam int AXIS_POINTS   = 5;
	localparam int MAP_COUNT     = 2;
	localparam int FRACTION_BITS = 12;

	localparam int CELLS_PER_MAP = AXIS_POINTS * AXIS_POINTS;
	localparam int MAP_DEPTH     = MAP_COUNT * CELLS_PER_MAP;
	localparam int ADDR_W        = $clog2(MAP_DEPTH);
	localparam int IDX_W         = $clog2(AXIS_POINTS);

	// Field and datapath widths
	localparam int VAL_W     = 16;
	localparam int CELL_W    = 2;
	localparam int FRAC_W    = FRACTION_BITS + 1;
	localparam int QRY_W     = VAL_W + 1;
	localparam int AB_W      = VAL_W + FRACTION_BITS + 2;
	localparam int MUL_A_W   = AB_W + 1;
	localparam int PROD_W    = MUL_A_W + FRAC_W + 1;
	localparam int X_W       = AB_W + FRACTION_BITS + 2;
	localparam int DIV_CNT_W = $clog2(FRACTION_BITS);

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRACTION_BITS;

	typedef enum logic [1:0] {
		OP_LOOKUP     = 2'd0,
		OP_WRITE_CELL = 2'd1,
		OP_WRITE_ROW  = 2'd2,
		OP_WRITE_COL  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_BP_LO,
		ST_BP_HI,
		ST_FRAC,
		ST_DIV,
		ST_CELL,
		ST_MUL_A,
		ST_MUL_B,
		ST_ADD_B,
		ST_MUL_X,
		ST_ADD_X
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic [FRACTION_BITS-1:0] quotient;
	} div_rsp_t;

	// Offset of the k-th corner cell from the lower-left corner
	function automatic logic [ADDR_W-1:0] cell_offset(input logic [1:0] k);
		logic [ADDR_W-1:0] off;
		unique case (k)
			2'd0: off = '0;
			2'd1: off = ADDR_W'(1);
			2'd2: off = ADDR_W'(AXIS_POINTS);
			2'd3: off = ADDR_W'(AXIS_POINTS + 1);
			default: off = '0;
		endcase
		return off;
	endfunction

endpackage

// File: rtl/core/breakpoint_map_bilinear_lookup.sv
// Table writes do not make the block busy; it is ready again in the next cycle.
// A lookup runs the segment search, the lower and upper breakpoint reads, one
// fraction per axis (direct, or by the 12-step serial divider), the four corner
// map reads and the steps on the shared multiplier, plus any wait on out_ready.
// No new input is accepted until the lookup has completed.
// Reset clears the sequencer and the output valid; tables are undefined until written.
module breakpoint_map_bilinear_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic                              map_select,
	input  logic [2:0]                        row_index,
	input  logic [2:0]                        col_index,
	input  logic signed [bmbl_pkg::VAL_W-1:0] write_value,
	input  logic signed [bmbl_pkg::VAL_W-1:0] row_query,
	input  logic signed [bmbl_pkg::VAL_W-1:0] col_query,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bmbl_pkg::VAL_W-1:0] interpolated,
	output logic [bmbl_pkg::CELL_W-1:0]       row_cell,
	output logic [bmbl_pkg::CELL_W-1:0]       col_cell
);

	bmbl_pkg::state_t state_q, state_d;

	logic accept;
	logic div_start;
	logic frac_load;
	logic out_load;
	bmbl_pkg::op_t op_in;

	// Tables
	logic signed [bmbl_pkg::VAL_W-1:0] row_bp_q [bmbl_pkg::AXIS_POINTS];
	logic signed [bmbl_pkg::VAL_W-1:0] col_bp_q [bmbl_pkg::AXIS_POINTS];
	logic signed [bmbl_pkg::VAL_W-1:0] map_mem_q [bmbl_pkg::MAP_DEPTH];
	logic signed [bmbl_pkg::VAL_W-1:0] rd_data_q;

	// Lookup context
	logic                              msel_q;
	logic signed [bmbl_pkg::VAL_W-1:0] rq_q, cq_q;
	logic [bmbl_pkg::IDX_W-1:0]        r_idx_q, c_idx_q;
	logic signed [bmbl_pkg::VAL_W-1:0] lo_r_q, hi_r_q, lo_c_q, hi_c_q;
	logic                              frac_sel_q;
	logic [bmbl_pkg::FRAC_W-1:0]       fr_q, fc_q;
	logic [2:0]                        cell_k_q;
	logic signed [bmbl_pkg::VAL_W-1:0] v_q [4];
	logic signed [bmbl_pkg::PROD_W-1:0] prod_q;
	logic signed [bmbl_pkg::AB_W-1:0]  a_q, b_q;

	// Output registers
	logic                              out_valid_q;
	logic signed [bmbl_pkg::VAL_W-1:0] interp_q;
	logic [bmbl_pkg::CELL_W-1:0]       row_cell_q, col_cell_q;

	logic row_ok, col_ok, map_ok_in, map_ok;
	logic [bmbl_pkg::ADDR_W-1:0] wr_addr, rd_addr;
	logic mem_we;

	logic [bmbl_pkg::IDX_W-1:0] r_addr, c_addr;
	logic signed [bmbl_pkg::VAL_W-1:0] row_bp_rd, col_bp_rd;
	logic r_step, c_step;

	logic signed [bmbl_pkg::VAL_W-1:0] f_lo, f_hi, f_q;
	logic signed [bmbl_pkg::QRY_W-1:0] f_num, f_den;
	logic f_zero, f_one;
	logic [bmbl_pkg::FRAC_W-1:0] frac_value;

	logic signed [bmbl_pkg::MUL_A_W-1:0] mul_a_op;
	logic signed [bmbl_pkg::FRAC_W:0]    mul_b_op;
	logic signed [bmbl_pkg::PROD_W-1:0]  prod_d;
	logic signed [bmbl_pkg::X_W-1:0]     x_d;
	logic [1:0]                          v_idx;

	bmbl_pkg::div_req_t div_req;
	bmbl_pkg::div_rsp_t div_rsp;

	assign accept = in_valid && in_ready;
	assign op_in  = bmbl_pkg::op_t'(operation);

	// Write address checks
	assign row_ok    = int'(row_index) < bmbl_pkg::AXIS_POINTS;
	assign col_ok    = int'(col_index) < bmbl_pkg::AXIS_POINTS;
	assign map_ok_in = int'(map_select) < bmbl_pkg::MAP_COUNT;
	assign map_ok    = int'(msel_q) < bmbl_pkg::MAP_COUNT;

	assign wr_addr = bmbl_pkg::ADDR_W'(int'(map_select) * bmbl_pkg::CELLS_PER_MAP
		+ int'(row_index) * bmbl_pkg::AXIS_POINTS + int'(col_index));
	assign rd_addr = bmbl_pkg::ADDR_W'(int'(msel_q) * bmbl_pkg::CELLS_PER_MAP
		+ int'(r_idx_q) * bmbl_pkg::AXIS_POINTS + int'(c_idx_q))
		+ bmbl_pkg::cell_offset(cell_k_q[1:0]);
	assign mem_we  = accept && (op_in == bmbl_pkg::OP_WRITE_CELL)
		&& map_ok_in && row_ok && col_ok;

	// Breakpoint read port: lower point in ST_BP_LO, upper point otherwise
	assign r_addr    = (state_q == bmbl_pkg::ST_BP_LO) ? r_idx_q
	                                                   : r_idx_q + bmbl_pkg::IDX_W'(1);
	assign c_addr    = (state_q == bmbl_pkg::ST_BP_LO) ? c_idx_q
	                                                   : c_idx_q + bmbl_pkg::IDX_W'(1);
	assign row_bp_rd = row_bp_q[r_addr];
	assign col_bp_rd = col_bp_q[c_addr];

	// Segment search: advance while the query lies above the upper point
	assign r_step = (int'(r_idx_q) < bmbl_pkg::AXIS_POINTS - 2) && (rq_q > row_bp_rd);
	assign c_step = (int'(c_idx_q) < bmbl_pkg::AXIS_POINTS - 2) && (cq_q > col_bp_rd);

	// Fraction setup, row axis first then column axis
	always_comb begin
		f_lo   = frac_sel_q ? lo_c_q : lo_r_q;
		f_hi   = frac_sel_q ? hi_c_q : hi_r_q;
		f_q    = frac_sel_q ? cq_q : rq_q;
		f_num  = bmbl_pkg::QRY_W'(f_q) - bmbl_pkg::QRY_W'(f_lo);
		f_den  = bmbl_pkg::QRY_W'(f_hi) - bmbl_pkg::QRY_W'(f_lo);
		f_zero = (f_den <= 0) || (f_num <= 0);
		f_one  = f_num >= f_den;
		if (state_q == bmbl_pkg::ST_DIV) begin
			frac_value = {1'b0, div_rsp.quotient};
		end else if (f_zero) begin
			frac_value = '0;
		end else begin
			frac_value = bmbl_pkg::FRAC_ONE;
		end
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = f_num[bmbl_pkg::VAL_W-1:0];
	assign div_req.divisor  = f_den[bmbl_pkg::VAL_W-1:0];

	bmbl_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Shared multiplier operands
	always_comb begin
		mul_a_op = '0;
		mul_b_op = '0;
		case (state_q)
			bmbl_pkg::ST_MUL_A: begin
				mul_a_op = bmbl_pkg::MUL_A_W'(v_q[1]) - bmbl_pkg::MUL_A_W'(v_q[0]);
				mul_b_op = {1'b0, fc_q};
			end
			bmbl_pkg::ST_MUL_B: begin
				mul_a_op = bmbl_pkg::MUL_A_W'(v_q[3]) - bmbl_pkg::MUL_A_W'(v_q[2]);
				mul_b_op = {1'b0, fc_q};
			end
			bmbl_pkg::ST_MUL_X: begin
				mul_a_op = bmbl_pkg::MUL_A_W'(b_q) - bmbl_pkg::MUL_A_W'(a_q);
				mul_b_op = {1'b0, fr_q};
			end
			default: begin
				mul_a_op = '0;
				mul_b_op = '0;
			end
		endcase
	end

	assign prod_d = mul_a_op * mul_b_op;
	assign x_d    = (bmbl_pkg::X_W'(a_q) <<< bmbl_pkg::FRACTION_BITS)
	                + bmbl_pkg::X_W'(prod_q);
	assign v_idx  = 2'(cell_k_q - 3'd1);

	// Sequencer
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		frac_load = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			bmbl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (op_in == bmbl_pkg::OP_LOOKUP)) begin
					state_d = bmbl_pkg::ST_SEARCH;
				end
			end
			bmbl_pkg::ST_SEARCH: begin
				if (!r_step && !c_step) begin
					state_d = bmbl_pkg::ST_BP_LO;
				end
			end
			bmbl_pkg::ST_BP_LO: state_d = bmbl_pkg::ST_BP_HI;
			bmbl_pkg::ST_BP_HI: state_d = bmbl_pkg::ST_FRAC;
			bmbl_pkg::ST_FRAC: begin
				if (f_zero || f_one) begin
					frac_load = 1'b1;
					state_d   = frac_sel_q ? bmbl_pkg::ST_CELL : bmbl_pkg::ST_FRAC;
				end else begin
					div_start = 1'b1;
					state_d   = bmbl_pkg::ST_DIV;
				end
			end
			bmbl_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					frac_load = 1'b1;
					state_d   = frac_sel_q ? bmbl_pkg::ST_CELL : bmbl_pkg::ST_FRAC;
				end
			end
			bmbl_pkg::ST_CELL: begin
				if (cell_k_q == 3'd4) begin
					state_d = bmbl_pkg::ST_MUL_A;
				end
			end
			bmbl_pkg::ST_MUL_A: state_d = bmbl_pkg::ST_MUL_B;
			bmbl_pkg::ST_MUL_B: state_d = bmbl_pkg::ST_ADD_B;
			bmbl_pkg::ST_ADD_B: state_d = bmbl_pkg::ST_MUL_X;
			bmbl_pkg::ST_MUL_X: state_d = bmbl_pkg::ST_ADD_X;
			bmbl_pkg::ST_ADD_X: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bmbl_pkg::ST_IDLE;
				end
			end
			default: state_d = bmbl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmbl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Map memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem_q[wr_addr] <= write_value;
		end
		rd_data_q <= map_mem_q[rd_addr];
	end

	// Breakpoint axes
	always_ff @(posedge clk) begin
		if (accept && (op_in == bmbl_pkg::OP_WRITE_ROW) && row_ok) begin
			row_bp_q[bmbl_pkg::IDX_W'(row_index)] <= write_value;
		end
		if (accept && (op_in == bmbl_pkg::OP_WRITE_COL) && col_ok) begin
			col_bp_q[bmbl_pkg::IDX_W'(col_index)] <= write_value;
		end
	end

	// Lookup datapath
	always_ff @(posedge clk) begin
		case (state_q)
			bmbl_pkg::ST_IDLE: begin
				msel_q  <= map_select;
				rq_q    <= row_query;
				cq_q    <= col_query;
				r_idx_q <= '0;
				c_idx_q <= '0;
			end
			bmbl_pkg::ST_SEARCH: begin
				if (r_step) begin
					r_idx_q <= r_idx_q + bmbl_pkg::IDX_W'(1);
				end
				if (c_step) begin
					c_idx_q <= c_idx_q + bmbl_pkg::IDX_W'(1);
				end
			end
			bmbl_pkg::ST_BP_LO: begin
				lo_r_q <= row_bp_rd;
				lo_c_q <= col_bp_rd;
			end
			bmbl_pkg::ST_BP_HI: begin
				hi_r_q     <= row_bp_rd;
				hi_c_q     <= col_bp_rd;
				frac_sel_q <= 1'b0;
			end
			bmbl_pkg::ST_FRAC, bmbl_pkg::ST_DIV: begin
				if (frac_load) begin
					if (frac_sel_q) begin
						fc_q <= frac_value;
					end else begin
						fr_q <= frac_value;
					end
					frac_sel_q <= 1'b1;
					cell_k_q   <= '0;
				end
			end
			bmbl_pkg::ST_CELL: begin
				cell_k_q <= cell_k_q + 3'd1;
				if (cell_k_q != 3'd0) begin
					v_q[v_idx] <= rd_data_q;
				end
			end
			bmbl_pkg::ST_MUL_A: prod_q <= prod_d;
			bmbl_pkg::ST_MUL_B: begin
				prod_q <= prod_d;
				a_q    <= (bmbl_pkg::AB_W'(v_q[0]) <<< bmbl_pkg::FRACTION_BITS)
				          + bmbl_pkg::AB_W'(prod_q);
			end
			bmbl_pkg::ST_ADD_B: begin
				b_q <= (bmbl_pkg::AB_W'(v_q[2]) <<< bmbl_pkg::FRACTION_BITS)
				       + bmbl_pkg::AB_W'(prod_q);
			end
			bmbl_pkg::ST_MUL_X: prod_q <= prod_d;
			default: begin
			end
		endcase
	end

	// Result register; arithmetic shift floors the value
	always_ff @(posedge clk) begin
		if (out_load) begin
			interp_q   <= map_ok ? x_d[2*bmbl_pkg::FRACTION_BITS +: bmbl_pkg::VAL_W] : '0;
			row_cell_q <= r_idx_q[bmbl_pkg::CELL_W-1:0];
			col_cell_q <= c_idx_q[bmbl_pkg::CELL_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign interpolated = interp_q;
	assign row_cell     = row_cell_q;
	assign col_cell     = col_cell_q;

endmodule

// File: rtl/core/bmbl_divider.sv
// Restoring divider, one quotient bit per cycle. Dividend is below divisor,
// so the quotient is a pure fraction of FRACTION_BITS bits.
module bmbl_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  bmbl_pkg::div_req_t  req,
	output bmbl_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [bmbl_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [bmbl_pkg::VAL_W-1:0]          rem_q;
	logic [bmbl_pkg::VAL_W-1:0]          den_q;
	logic [bmbl_pkg::FRACTION_BITS-1:0]  quo_q;

	logic [bmbl_pkg::VAL_W:0]   rem2;
	logic                       ge;
	logic [bmbl_pkg::VAL_W-1:0] rem_next;

	// Shift, trial subtract, keep or restore
	always_comb begin
		rem2     = {rem_q, 1'b0};
		ge       = rem2 >= {1'b0, den_q};
		rem_next = ge ? bmbl_pkg::VAL_W'(rem2 - {1'b0, den_q})
		              : bmbl_pkg::VAL_W'(rem2);
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + bmbl_pkg::DIV_CNT_W'(1);
				if (cnt_q == bmbl_pkg::DIV_CNT_W'(bmbl_pkg::FRACTION_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			den_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[bmbl_pkg::FRACTION_BITS-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: rtl/core/bmbl_checker.sv
`include "breakpoint_map_bilinear_lookup_macros.svh"

// Port-level checks of the breakpoint map lookup
module bmbl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [1:0]                        operation,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [bmbl_pkg::VAL_W-1:0] interpolated,
	input logic [bmbl_pkg::CELL_W-1:0]       row_cell,
	input logic [bmbl_pkg::CELL_W-1:0]       col_cell
);

	// A stalled result stays and keeps its payload
	`BMBL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`BMBL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(interpolated) && $stable(row_cell) && $stable(col_cell))

	// Table writes leave the block ready in the next cycle
	`BMBL_ASSERT_NEXT(a_write_single, in_valid && in_ready && operation != bmbl_pkg::OP_LOOKUP, in_ready)

	// A lookup keeps the block busy
	`BMBL_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && operation == bmbl_pkg::OP_LOOKUP, !in_ready)

	// A new result appears only as the sequencer returns to idle
	`BMBL_ASSERT_SAME(a_result_idle, $rose(out_valid), in_ready)

endmodule

bind breakpoint_map_bilinear_lookup bmbl_checker u_checker (.*);
